@@ rtl/bel_pkg.sv @@
`default_nettype none
package bel_pkg;

   localparam int MAX_LEVEL   = 125;
   localparam int COUNT_WIDTH = 16;
   localparam int STACK_DEPTH = 127;
   localparam int SP_W        = 7;
   localparam int LVL_W       = 7;
   localparam int CLS_W       = 5;
   localparam int ISO_W       = 7;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [ISO_W-1:0]       ISO_MAX   = '1;
   localparam logic [SP_W-1:0]        SP_LAST   = SP_W'(STACK_DEPTH - 1);

   localparam logic [CLS_W-1:0] CL_L   = 5'd1;
   localparam logic [CLS_W-1:0] CL_R   = 5'd2;
   localparam logic [CLS_W-1:0] CL_BN  = 5'd10;
   localparam logic [CLS_W-1:0] CL_B   = 5'd13;
   localparam logic [CLS_W-1:0] CL_RLO = 5'd14;
   localparam logic [CLS_W-1:0] CL_RLE = 5'd15;
   localparam logic [CLS_W-1:0] CL_LRO = 5'd16;
   localparam logic [CLS_W-1:0] CL_LRE = 5'd17;
   localparam logic [CLS_W-1:0] CL_PDF = 5'd18;
   localparam logic [CLS_W-1:0] CL_LRI = 5'd19;
   localparam logic [CLS_W-1:0] CL_RLI = 5'd20;
   localparam logic [CLS_W-1:0] CL_FSI = 5'd21;
   localparam logic [CLS_W-1:0] CL_PDI = 5'd22;

   typedef enum logic [1:0] {
      OVR_NONE = 2'd0,
      OVR_L    = 2'd1,
      OVR_R    = 2'd2
   } ovr_type;

   typedef enum logic [2:0] {
      OP_PLAIN,
      OP_KEEP,
      OP_EMB,
      OP_ISO,
      OP_PDF,
      OP_PDI
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FILL,
      S_SCAN,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [LVL_W-1:0] lvl;
      ovr_type          ovr;
      logic             iso;
   } entry_type;

   typedef struct packed {
      op_type           op;
      logic             rtl;
      ovr_type          ovr;
      logic [CLS_W-1:0] cls;
      logic             last;
   } work_type;

   function automatic logic [LVL_W:0] next_level(input logic [LVL_W-1:0] cur,
                                                 input logic rtl);
      logic [LVL_W:0] base;
      base = {1'b0, cur};
      if (rtl == cur[0]) begin
         next_level = base + (LVL_W+1)'(2);
      end else begin
         next_level = base + (LVL_W+1)'(1);
      end
   endfunction

endpackage
`default_nettype wire

@@ rtl/bel_if.sv @@
`default_nettype none
interface bel_req_if
   import bel_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CLS_W-1:0] char_class;
   logic             fsi_rtl;
   logic             last_in_text;
   modport source (output valid, char_class, fsi_rtl, last_in_text, input ready);
   modport sink   (input valid, char_class, fsi_rtl, last_in_text, output ready);
endinterface

interface bel_rsp_if
   import bel_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [LVL_W-1:0] level;
   logic [CLS_W-1:0] class_out;
   logic             last_out;
   modport source (output valid, level, class_out, last_out, input ready);
   modport sink   (input valid, level, class_out, last_out, output ready);
endinterface
`default_nettype wire

@@ rtl/bel_ram.sv @@
`default_nettype none
module bel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ rtl/bel_front.sv @@
`default_nettype none
module bel_front
   import bel_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   bel_req_if.sink       req_bus,
   output logic          q_valid,
   output work_type      q_head,
   input  wire logic     q_pop
);
   work_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   work_type   cls_work;
   logic       push;

   // classify the incoming beat
   always_comb begin
      cls_work.op   = OP_PLAIN;
      cls_work.rtl  = 1'b0;
      cls_work.ovr  = OVR_NONE;
      cls_work.cls  = req_bus.char_class;
      cls_work.last = req_bus.last_in_text;
      case (req_bus.char_class)
         CL_RLE: begin cls_work.op = OP_EMB; cls_work.rtl = 1'b1; end
         CL_LRE: begin cls_work.op = OP_EMB; end
         CL_RLO: begin cls_work.op = OP_EMB; cls_work.rtl = 1'b1; cls_work.ovr = OVR_R; end
         CL_LRO: begin cls_work.op = OP_EMB; cls_work.ovr = OVR_L; end
         CL_RLI: begin cls_work.op = OP_ISO; cls_work.rtl = 1'b1; end
         CL_LRI: begin cls_work.op = OP_ISO; end
         CL_FSI: begin cls_work.op = OP_ISO; cls_work.rtl = req_bus.fsi_rtl; end
         CL_PDF: begin cls_work.op = OP_PDF; end
         CL_PDI: begin cls_work.op = OP_PDI; end
         CL_BN, CL_B: begin cls_work.op = OP_KEEP; end
         default: begin cls_work.op = OP_PLAIN; end
      endcase
   end

   assign req_bus.ready = (cnt_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign q_valid       = (cnt_ff != 2'd0);
   assign q_head        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cls_work;
      end
   end
endmodule
`default_nettype wire

@@ rtl/bel_back.sv @@
`default_nettype none
module bel_back
   import bel_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [LVL_W-1:0] base_level,
   input  wire logic             q_valid,
   input  work_type              q_head,
   output logic                  q_pop,
   bel_rsp_if.source             rsp_bus
);
   state_type              state_ff, state_in;
   logic [SP_W-1:0]        sp_ff, sp_in;
   logic [COUNT_WIDTH-1:0] ovf_iso_ff, ovf_iso_in;
   logic [COUNT_WIDTH-1:0] ovf_emb_ff, ovf_emb_in;
   logic [ISO_W-1:0]       open_iso_ff, open_iso_in;
   entry_type              top_ff, top_in;
   logic                   fin_ff, fin_in;
   logic                   scan_ff, scan_in;
   work_type               pend_ff, pend_in;
   logic                   out_valid_ff, out_valid_in;
   logic [LVL_W-1:0]       out_lvl_ff, out_lvl_in;
   logic [CLS_W-1:0]       out_cls_ff, out_cls_in;
   logic                   out_last_ff, out_last_in;

   logic [LVL_W-1:0] top_lvl;
   ovr_type          top_ovr;
   logic             top_iso;
   logic             slot_free, take, pdi_scan;
   logic [LVL_W:0]   nl;
   logic             may_push, room;
   logic [SP_W-1:0]  sp_dn;
   logic             ram_we;
   entry_type        ram_wdata, ram_rdata;
   logic             pdf_pop;

   assign top_lvl   = (sp_ff == '0) ? base_level : top_ff.lvl;
   assign top_ovr   = (sp_ff == '0) ? OVR_NONE : top_ff.ovr;
   assign top_iso   = (sp_ff == '0) ? 1'b0 : top_ff.iso;
   assign slot_free = !out_valid_ff || rsp_bus.ready;
   assign take      = (state_ff == S_IDLE) && q_valid && slot_free;
   assign pdi_scan  = (q_head.op == OP_PDI) && (ovf_iso_ff == '0) && (open_iso_ff != '0);
   assign nl        = next_level(top_lvl, q_head.rtl);
   assign may_push  = (nl <= (LVL_W+1)'(MAX_LEVEL)) && (ovf_iso_ff == '0) && (ovf_emb_ff == '0);
   assign room      = (sp_ff != SP_LAST);
   assign sp_dn     = sp_ff - SP_W'(1);
   assign pdf_pop   = (ovf_iso_ff == '0) && (ovf_emb_ff == '0) && (sp_ff != '0) && !top_iso;

   bel_ram #(.WIDTH($bits(entry_type)), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (sp_ff + SP_W'(1)),
      .wr_data (ram_wdata),
      .rd_addr (sp_dn),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (q_head.op == OP_PDI && pdi_scan) begin
                  state_in = S_SCAN;
               end else if (q_head.op == OP_PDF && pdf_pop && sp_dn != '0 && !q_head.last) begin
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            if (!scan_ff)    state_in = S_IDLE;
            else if (fin_ff) state_in = S_EMIT;
            else             state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sp_ff == '0 || sp_dn == '0) state_in = S_EMIT;
            else                            state_in = S_FILL;
         end
         S_EMIT: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      sp_in        = sp_ff;
      ovf_iso_in   = ovf_iso_ff;
      ovf_emb_in   = ovf_emb_ff;
      open_iso_in  = open_iso_ff;
      top_in       = top_ff;
      fin_in       = fin_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_lvl_in   = out_lvl_ff;
      out_cls_in   = out_cls_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_wdata.lvl = nl[LVL_W-1:0];
      ram_wdata.ovr = (q_head.op == OP_EMB) ? q_head.ovr : OVR_NONE;
      ram_wdata.iso = (q_head.op == OP_ISO);
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               q_pop       = 1'b1;
               pend_in     = q_head;
               out_valid_in = 1'b1;
               out_lvl_in  = top_lvl;
               out_cls_in  = q_head.cls;
               out_last_in = q_head.last;
               scan_in     = 1'b0;
               fin_in      = 1'b0;
               case (q_head.op)
                  OP_PLAIN: begin
                     if (top_ovr != OVR_NONE) out_cls_in = CLS_W'(top_ovr);
                  end
                  OP_EMB: begin
                     out_cls_in = CL_BN;
                     if (may_push) begin
                        if (room) begin
                           sp_in  = sp_ff + SP_W'(1);
                           ram_we = 1'b1;
                           top_in = ram_wdata;
                        end
                     end else if (ovf_iso_ff == '0 && ovf_emb_ff != COUNT_MAX) begin
                        ovf_emb_in = ovf_emb_ff + COUNT_WIDTH'(1);
                     end
                  end
                  OP_ISO: begin
                     if (may_push && room) begin
                        sp_in  = sp_ff + SP_W'(1);
                        ram_we = 1'b1;
                        top_in = ram_wdata;
                        if (open_iso_ff != ISO_MAX) open_iso_in = open_iso_ff + ISO_W'(1);
                     end else if (ovf_iso_ff != COUNT_MAX) begin
                        ovf_iso_in = ovf_iso_ff + COUNT_WIDTH'(1);
                     end
                  end
                  OP_PDF: begin
                     out_cls_in = CL_BN;
                     if (ovf_iso_ff == '0 && ovf_emb_ff != '0) begin
                        ovf_emb_in = ovf_emb_ff - COUNT_WIDTH'(1);
                     end else if (pdf_pop) begin
                        sp_in = sp_dn;
                     end
                  end
                  OP_PDI: begin
                     if (ovf_iso_ff != '0) begin
                        ovf_iso_in = ovf_iso_ff - COUNT_WIDTH'(1);
                     end else if (pdi_scan) begin
                        out_valid_in = out_valid_ff && !rsp_bus.ready;
                        out_lvl_in   = out_lvl_ff;
                        out_cls_in   = out_cls_ff;
                        out_last_in  = out_last_ff;
                        ovf_emb_in   = '0;
                        open_iso_in  = open_iso_ff - ISO_W'(1);
                        scan_in      = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               // drop all text state after the last character
               if (q_head.last && !(q_head.op == OP_PDI && pdi_scan)) begin
                  sp_in       = '0;
                  ovf_iso_in  = '0;
                  ovf_emb_in  = '0;
                  open_iso_in = '0;
               end
            end
         end
         S_FILL: begin
            top_in = ram_rdata;
         end
         S_SCAN: begin
            if (sp_ff != '0) begin
               sp_in  = sp_dn;
               fin_in = top_iso;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_lvl_in   = top_lvl;
               out_cls_in   = pend_ff.cls;
               out_last_in  = pend_ff.last;
               if (pend_ff.last) begin
                  sp_in       = '0;
                  ovf_iso_in  = '0;
                  ovf_emb_in  = '0;
                  open_iso_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         ovf_iso_ff   <= '0;
         ovf_emb_ff   <= '0;
         open_iso_ff  <= '0;
         fin_ff       <= 1'b0;
         scan_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         ovf_iso_ff   <= ovf_iso_in;
         ovf_emb_ff   <= ovf_emb_in;
         open_iso_ff  <= open_iso_in;
         fin_ff       <= fin_in;
         scan_ff      <= scan_in;
         out_valid_ff <= out_valid_in;
      end
      top_ff      <= top_in;
      pend_ff     <= pend_in;
      out_lvl_ff  <= out_lvl_in;
      out_cls_ff  <= out_cls_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.level     = out_lvl_ff;
   assign rsp_bus.class_out = out_cls_ff;
   assign rsp_bus.last_out  = out_last_ff;
endmodule
`default_nettype wire

@@ rtl/bidi_explicit_level_resolver.sv @@
`default_nettype none
// Channel   Dir  Payload                               Beat when
// req_bus   in   char_class[5] fsi_rtl last_in_text    valid && ready
// rsp_bus   out  level[7] class_out[5] last_out        valid && ready
// csr_*     in   csr_wr_data[7] = base_level           csr_wr_en
//
// Most classes take one beat per cycle while rsp_bus is not stalled; a
// PDF that pops to a non-bottom entry reloads the top entry through the
// registered stack RAM read; a PDI that closes an isolate pops entries in
// S_SCAN, reloading each in S_FILL but the bottom one, then emits in S_EMIT.
// Reset clears the queue, stack pointer and counters; the stack RAM needs
// no clearing since an entry is always written before it is read back.
// A two-beat queue lets the front take beats while the back walks the
// stack; the output register holds a result while rsp_bus stalls.
module bidi_explicit_level_resolver
   import bel_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   bel_req_if.sink               req_bus,
   bel_rsp_if.source             rsp_bus,
   input  wire logic             csr_wr_en,
   input  wire logic [LVL_W-1:0] csr_wr_data
);
   logic [LVL_W-1:0] base_level_ff, base_level_in;
   logic             q_valid;
   work_type         q_head;
   logic             q_pop;

   // hold base level until software writes it
   assign base_level_in = csr_wr_en ? csr_wr_data : base_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_level_ff <= '0;
      end else begin
         base_level_ff <= base_level_in;
      end
   end

   // front: classify beats and queue them
   bel_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   // back: run the stack and drive results
   bel_back u_back (
      .clock      (clock),
      .reset      (reset),
      .base_level (base_level_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_bus    (rsp_bus)
   );
endmodule
`default_nettype wire

@@ rtl/bel_checker.sv @@
`default_nettype none
module bel_checker
   import bel_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [LVL_W-1:0] rsp_level,
   input wire logic [CLS_W-1:0] rsp_class_out,
   input wire logic             rsp_last_out
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_level) && $stable(rsp_class_out)
                                  && $stable(rsp_last_out))
      else $error("rsp payload changed while stalled");

   a_no_embed_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_class_out != CL_RLO && rsp_class_out != CL_RLE &&
                    rsp_class_out != CL_LRO && rsp_class_out != CL_LRE &&
                    rsp_class_out != CL_PDF)
      else $error("embedding code not turned into BN");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind bidi_explicit_level_resolver bel_checker u_bel_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_level     (rsp_bus.level),
   .rsp_class_out (rsp_bus.class_out),
   .rsp_last_out  (rsp_bus.last_out)
);
`default_nettype wire

@@ bench/bel_tb_if.sv @@
`default_nettype none
// Channel interfaces are provided with the RTL (bel_req_if, bel_rsp_if).
// This file holds a small bundle for the watch-only side of the checker.
interface bel_cfg_if
   import bel_pkg::*;
();
   logic             wr_en;
   logic [LVL_W-1:0] wr_data;
   modport source (output wr_en, wr_data);
   modport sink   (input wr_en, wr_data);
endinterface
`default_nettype wire

@@ bench/bel_level_checker.sv @@
`default_nettype none
module bel_level_checker
   import bel_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   bel_req_if.sink               req_mon,
   bel_rsp_if.sink               rsp_mon,
   bel_cfg_if.sink               cfg_mon,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [LVL_W-1:0] lvl;
      logic [CLS_W-1:0] cls;
      logic             last;
   } level_result_t;

   level_result_t    level_queue[$];
   logic [LVL_W-1:0] para_level;
   logic [LVL_W-1:0] lvl_stk[STACK_DEPTH];
   ovr_type          ovr_stk[STACK_DEPTH];
   logic             iso_stk[STACK_DEPTH];
   int               depth;
   int unsigned      ovf_iso, ovf_emb, iso_open;
   localparam int unsigned CNT_TOP = (1 << COUNT_WIDTH) - 1;

   assign pending_count = level_queue.size();

   function automatic logic [LVL_W-1:0] cur_level();
      return (depth == 0) ? para_level : lvl_stk[depth];
   endfunction

   function automatic int unsigned raise_level(int unsigned cur, logic rtl);
      if (rtl) return cur[0] ? cur + 2 : cur + 1;
      return cur[0] ? cur + 1 : cur + 2;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic open_emb(input logic rtl, input ovr_type ovr);
      int unsigned nl;
      nl = raise_level(cur_level(), rtl);
      if (nl <= MAX_LEVEL && ovf_iso == 0 && ovf_emb == 0) begin
         if (depth + 1 < STACK_DEPTH) begin
            depth++;
            lvl_stk[depth] = nl[LVL_W-1:0];
            ovr_stk[depth] = ovr;
            iso_stk[depth] = 1'b0;
         end
      end else if (ovf_iso == 0 && ovf_emb < CNT_TOP) begin
         ovf_emb++;
      end
   endtask

   task automatic open_iso(input logic rtl);
      int unsigned nl;
      nl = raise_level(cur_level(), rtl);
      if (nl <= MAX_LEVEL && ovf_iso == 0 && ovf_emb == 0 && depth + 1 < STACK_DEPTH) begin
         depth++;
         lvl_stk[depth] = nl[LVL_W-1:0];
         ovr_stk[depth] = OVR_NONE;
         iso_stk[depth] = 1'b1;
         if (iso_open < 127) iso_open++;
      end else if (ovf_iso < CNT_TOP) begin
         ovf_iso++;
      end
   endtask

   // Predict one character and advance the stack model.
   task automatic predict_level(input logic [CLS_W-1:0] cls, input logic rtl, input logic last);
      level_result_t r;
      r.lvl  = cur_level();
      r.cls  = cls;
      r.last = last;
      case (cls)
         CL_RLE: begin open_emb(1'b1, OVR_NONE); r.cls = CL_BN; end
         CL_LRE: begin open_emb(1'b0, OVR_NONE); r.cls = CL_BN; end
         CL_RLO: begin open_emb(1'b1, OVR_R); r.cls = CL_BN; end
         CL_LRO: begin open_emb(1'b0, OVR_L); r.cls = CL_BN; end
         CL_RLI: open_iso(1'b1);
         CL_LRI: open_iso(1'b0);
         CL_FSI: open_iso(rtl);
         CL_PDI: begin
            if (ovf_iso != 0) ovf_iso--;
            else if (iso_open != 0) begin
               ovf_emb = 0;
               while (depth != 0 && !iso_stk[depth]) depth--;
               if (depth != 0) depth--;
               iso_open--;
            end
            r.lvl = cur_level();
         end
         CL_PDF: begin
            r.cls = CL_BN;
            if (ovf_iso == 0) begin
               if (ovf_emb != 0) ovf_emb--;
               else if (depth != 0 && !iso_stk[depth]) depth--;
            end
         end
         CL_BN, CL_B: ;
         default: if (depth != 0 && ovr_stk[depth] != OVR_NONE) r.cls = CLS_W'(ovr_stk[depth]);
      endcase
      level_queue.push_back(r);
      if (last) begin
         depth = 0; ovf_iso = 0; ovf_emb = 0; iso_open = 0;
      end
   endtask

   always @(posedge clock) begin
      level_result_t w;
      if (reset) begin
         para_level = '0;
         depth = 0; ovf_iso = 0; ovf_emb = 0; iso_open = 0;
         fail_count = 0;
         level_queue.delete();
      end else begin
         // a register write lands before any beat of this edge is resolved
         if (cfg_mon.wr_en) para_level = cfg_mon.wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (level_queue.size() == 0) begin
               report("unexpected beat, level", rsp_mon.level, -1);
            end else begin
               w = level_queue.pop_front();
               if (rsp_mon.level !== w.lvl) report("level", rsp_mon.level, w.lvl);
               if (rsp_mon.class_out !== w.cls) report("class_out", rsp_mon.class_out, w.cls);
               if (rsp_mon.last_out !== w.last) report("last_out", rsp_mon.last_out, w.last);
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_level(req_mon.char_class, req_mon.fsi_rtl, req_mon.last_in_text);
      end
   end
endmodule
`default_nettype wire

@@ bench/bidi_explicit_level_resolver_tb.sv @@
`default_nettype none
module bidi_explicit_level_resolver_tb;
   import bel_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [LVL_W-1:0] csr_wr_data = '0;
   int fail_count, pending_count;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   bit hold_done = 1'b0;
   bit stall_on = 1'b1;

   bel_req_if req_bus();
   bel_rsp_if rsp_bus();
   bel_cfg_if cfg_bus();

   assign cfg_bus.wr_en   = csr_wr_en;
   assign cfg_bus.wr_data = csr_wr_data;

   bidi_explicit_level_resolver u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   bel_level_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_bus.sink), .rsp_mon(rsp_bus.sink),
      .cfg_mon(cfg_bus.sink), .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: a random stall pattern, stretches of constant ready, and a long
   // hold-off (counted here) once the stimulus side asks for one.
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         for (hold = 0; hold < 300; hold++) @(posedge clock);
         hold_done = 1'b1;
         rsp_bus.ready <= 1'b1;
      end else if (stall_on) begin
         rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: count cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   int gap_left = 0;

   // Offer one character and hold it until it is accepted; gaps come first.
   task automatic send_char(input logic [CLS_W-1:0] cls, input logic rtl, input logic last);
      if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.char_class <= cls;
      req_bus.fsi_rtl <= rtl;
      req_bus.last_in_text <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid, drain every expected beat, let the back end settle, then write.
   task automatic set_base(input logic [LVL_W-1:0] val);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CLS_W-1:0] pick_class();
      int k;
      k = $urandom_range(0, 99);
      if (k < 12) return CL_PDF;
      if (k < 22) return CL_PDI;
      if (k < 42) return CLS_W'($urandom_range(CL_RLO, CL_LRE));
      if (k < 54) return CLS_W'($urandom_range(CL_LRI, CL_FSI));
      if (k < 58) return CLS_W'($urandom_range(23, 31));
      return CLS_W'($urandom_range(0, 13));
   endfunction

   initial begin
      int n, t, len, deep;
      logic [LVL_W-1:0] bases[5];
      bases = '{7'd0, 7'd1, 7'd124, 7'd125, 7'd127};
      req_bus.valid <= 1'b0;
      req_bus.char_class <= '0;
      req_bus.fsi_rtl <= 1'b0;
      req_bus.last_in_text <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each named class, overrides, both FSI directions, stray closers.
      send_char(CL_PDF, 1'b0, 1'b0);
      send_char(CL_PDI, 1'b0, 1'b0);
      send_char(CL_RLO, 1'b0, 1'b0);
      send_char(CL_L, 1'b0, 1'b0);
      send_char(CL_LRO, 1'b0, 1'b0);
      send_char(CL_R, 1'b0, 1'b0);
      send_char(CL_BN, 1'b0, 1'b0);
      send_char(CL_B, 1'b0, 1'b0);
      send_char(5'd31, 1'b0, 1'b0);
      send_char(CL_FSI, 1'b1, 1'b0);
      send_char(CL_PDF, 1'b0, 1'b0);
      send_char(CL_FSI, 1'b0, 1'b0);
      send_char(CL_RLE, 1'b0, 1'b0);
      send_char(CL_LRE, 1'b0, 1'b0);
      send_char(CL_LRI, 1'b0, 1'b0);
      send_char(CL_RLI, 1'b0, 1'b0);
      send_char(CL_PDI, 1'b0, 1'b0);
      send_char(CL_PDI, 1'b0, 1'b0);
      send_char(CL_PDI, 1'b0, 1'b0);
      send_char(5'd4, 1'b1, 1'b1);

      // Directed: deep nesting of embeddings and isolates, then unwind.
      for (n = 0; n < 70; n++) send_char(n[0] ? CL_RLE : CL_LRI, n[1], 1'b0);
      for (n = 0; n < 40; n++) send_char(n[0] ? CL_PDI : CL_PDF, 1'b0, 1'b0);
      send_char(CL_PDI, 1'b0, 1'b1);

      // Random phases over several paragraph levels; the long hold-off fills the block.
      for (t = 0; t < 5; t++) begin
         set_base(bases[t]);
         stall_on = (t != 2);
         if (t == 1) hold_off = 1'b1;
         for (n = 0; n < 260; n += len) begin
            len = $urandom_range(1, 60);
            deep = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
               if (deep && i < len / 2)
                  send_char(CLS_W'($urandom_range(CL_RLO, CL_FSI)), $urandom_range(0, 1), 1'b0);
               else
                  send_char(pick_class(), $urandom_range(0, 1), i == len - 1);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : 1;
            end
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
